>>> rtl/fvn_pkg.sv
// shared types and constants of the force vector norm reduction block
`timescale 1ns / 1ps
`default_nettype none

package fvn_pkg;

   localparam int COMPONENTS    = 3;
   localparam int COMP_W        = 24;
   localparam int SQ_W          = 2 * COMP_W;
   localparam int LANE_SUM_W    = SQ_W + 2;
   localparam int SUM_W         = 64;
   localparam int ROOT_W        = SUM_W / 2;
   localparam int CNT_W         = 17;
   localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;

   typedef struct packed {
      logic [COMP_W-1:0] mag;
      logic [SQ_W-1:0]   sq;
   } lane_type;

   typedef struct packed {
      logic [COMP_W-1:0] max_abs;
      logic [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]  count;
      logic              sat;
   } acc_type;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_START_ROOT,
      ST_ROOT,
      ST_DIV
   } ctrl_state_type;

endpackage

`default_nettype wire

>>> rtl/fvn_lane.sv
// one component lane: magnitude and square of a force component
`timescale 1ns / 1ps
`default_nettype none

module fvn_lane (
   input  wire logic                                clock,
   input  wire logic signed [fvn_pkg::COMP_W-1:0]   comp,
   output fvn_pkg::lane_type                        result
);

   logic [fvn_pkg::COMP_W-1:0] comp_u;
   logic [fvn_pkg::COMP_W-1:0] mag;
   logic [fvn_pkg::SQ_W-1:0]   sq;
   fvn_pkg::lane_type          result_ff;
   fvn_pkg::lane_type          result_in;

   assign comp_u = unsigned'(comp);
   // most negative value negates to itself, which reads right as unsigned
   assign mag    = comp_u[fvn_pkg::COMP_W-1] ? (~comp_u + 1'b1) : comp_u;
   assign sq     = mag * mag;

   always_comb begin
      result_in.mag = mag;
      result_in.sq  = sq;
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

>>> rtl/fvn_merge.sv
// merging stage: running maximum, saturating sum of squares and atom count
`timescale 1ns / 1ps
`default_nettype none

module fvn_merge #(
   parameter int unsigned COUNT_CAP = 65536
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    valid,
   input  wire logic                                    clear,
   input  fvn_pkg::lane_type [fvn_pkg::COMPONENTS-1:0]  lanes,
   output fvn_pkg::acc_type                             acc
);

   localparam logic [fvn_pkg::CNT_W-1:0] CAP = fvn_pkg::CNT_W'(COUNT_CAP);

   fvn_pkg::acc_type               acc_ff;
   fvn_pkg::acc_type               acc_in;
   logic [fvn_pkg::COMP_W-1:0]     lane_max;
   logic [fvn_pkg::LANE_SUM_W-1:0] lane_sum;
   logic [fvn_pkg::SUM_W:0]        total;

   always_comb begin
      lane_max = acc_ff.max_abs;
      lane_sum = '0;
      for (int i = 0; i < fvn_pkg::COMPONENTS; i++) begin
         if (lanes[i].mag > lane_max) begin
            lane_max = lanes[i].mag;
         end
         lane_sum = lane_sum + fvn_pkg::LANE_SUM_W'(lanes[i].sq);
      end
      total = {1'b0, acc_ff.sum} + (fvn_pkg::SUM_W + 1)'(lane_sum);

      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (valid) begin
         acc_in.max_abs = lane_max;
         if (total[fvn_pkg::SUM_W]) begin
            acc_in.sum = '1;
            acc_in.sat = 1'b1;
         end else begin
            acc_in.sum = total[fvn_pkg::SUM_W-1:0];
         end
         if (acc_ff.count < CAP) begin
            acc_in.count = acc_ff.count + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

>>> rtl/fvn_root.sv
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module fvn_root (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [fvn_pkg::SUM_W-1:0]    radicand,
   output logic                              done,
   output logic [fvn_pkg::ROOT_W-1:0]        root
);

   localparam int STEP_W = $clog2(fvn_pkg::ROOT_W);
   localparam int REM_W  = fvn_pkg::ROOT_W + 2;

   logic [fvn_pkg::SUM_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [fvn_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [REM_W-1:0]           rem_shift;
   logic [REM_W-1:0]           trial;
   logic                       fits;

   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[fvn_pkg::SUM_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign fits      = rem_shift >= trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         step_in = '1;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in  = {rad_ff[fvn_pkg::SUM_W-3:0], 2'b00};
         rem_in  = fits ? (rem_shift - trial) : rem_shift;
         root_in = {root_ff[fvn_pkg::ROOT_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

>>> rtl/fvn_div.sv
// iterative restoring divider of the norm by the atom count
`timescale 1ns / 1ps
`default_nettype none

module fvn_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [fvn_pkg::ROOT_W-1:0]   dividend,
   input  wire logic [fvn_pkg::CNT_W-1:0]    divisor,
   output logic                              done,
   output logic [fvn_pkg::ROOT_W-1:0]        quotient
);

   localparam int STEP_W = $clog2(fvn_pkg::ROOT_W);

   logic [fvn_pkg::ROOT_W-1:0] quo_ff, quo_in;
   logic [fvn_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [fvn_pkg::CNT_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [fvn_pkg::CNT_W:0]    rem_shift;
   logic [fvn_pkg::CNT_W:0]    diff;
   logic                       fits;

   // dividend bits shift out of the top of the quotient register
   assign rem_shift = {rem_ff, quo_ff[fvn_pkg::ROOT_W-1]};
   assign fits      = rem_shift >= {1'b0, dvs_ff};
   assign diff      = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = '1;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = fits ? diff[fvn_pkg::CNT_W-1:0] : rem_shift[fvn_pkg::CNT_W-1:0];
         quo_in  = {quo_ff[fvn_pkg::ROOT_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/force_vector_norm_reduce_unit.sv
// top level of the force vector max-abs and norm reduction block
`timescale 1ns / 1ps
`default_nettype none

// Takes one atom's x, y and z force components per item, one item per cycle
// while busy is low. Three component lanes form magnitudes and squares side
// by side and a merging stage keeps the largest magnitude, a saturating sum
// of squares and the atom count. The item marked last holds busy high
// through the pipeline and hand-off, a 32-step square root and a
// 32-step divide, one bit each per cycle, each handing on its answer
// with a done strobe. The result then appears on the rsp_ ports with
// rsp_strobe high for one cycle; nothing can hold it off.
// Items not marked last give no result. MAX_ATOMS caps the atom count.

module force_vector_norm_reduce_unit #(
   parameter int unsigned MAX_ATOMS = 65536
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [fvn_pkg::COMP_W-1:0]   req_comp_x,
   input  wire logic signed [fvn_pkg::COMP_W-1:0]   req_comp_y,
   input  wire logic signed [fvn_pkg::COMP_W-1:0]   req_comp_z,
   input  wire logic                                req_last_atom,
   output logic                                     rsp_strobe,
   output logic [fvn_pkg::COMP_W-1:0]               rsp_max_abs_comp,
   output logic [fvn_pkg::ROOT_W-1:0]               rsp_norm_value,
   output logic [fvn_pkg::ROOT_W-1:0]               rsp_norm_per_atom,
   output logic [fvn_pkg::CNT_W-1:0]                rsp_atoms_seen,
   output logic                                     rsp_sum_saturated
);

   localparam int unsigned COUNT_CAP =
      (MAX_ATOMS < fvn_pkg::CNT_FIELD_MAX) ? MAX_ATOMS : fvn_pkg::CNT_FIELD_MAX;

   fvn_pkg::ctrl_state_type                   state_ff, state_in;
   logic                                      s1_valid_ff, s1_valid_in;
   logic                                      s1_last_ff, s1_last_in;
   logic                                      accept;
   logic                                      merge_clear;
   logic                                      root_start;
   logic                                      root_done;
   logic [fvn_pkg::ROOT_W-1:0]                root_value;
   logic                                      div_start;
   logic                                      div_done;
   logic [fvn_pkg::ROOT_W-1:0]                div_value;
   logic [fvn_pkg::ROOT_W-1:0]                norm_ff, norm_in;
   fvn_pkg::acc_type                          acc;
   fvn_pkg::lane_type [fvn_pkg::COMPONENTS-1:0] lanes;
   logic signed [fvn_pkg::COMP_W-1:0]         comps [fvn_pkg::COMPONENTS];

   logic                                      strobe_ff, strobe_in;
   logic [fvn_pkg::COMP_W-1:0]                max_ff, max_in;
   logic [fvn_pkg::ROOT_W-1:0]                rnorm_ff, rnorm_in;
   logic [fvn_pkg::ROOT_W-1:0]                ratio_ff, ratio_in;
   logic [fvn_pkg::CNT_W-1:0]                 count_ff, count_in;
   logic                                      sat_ff, sat_in;

   assign busy   = (state_ff != fvn_pkg::ST_ACCUM) || (s1_valid_ff && s1_last_ff);
   assign accept = start && !busy;

   assign comps[0] = req_comp_x;
   assign comps[1] = req_comp_y;
   assign comps[2] = req_comp_z;

   for (genvar g = 0; g < fvn_pkg::COMPONENTS; g++) begin : g_lane
      fvn_lane u_lane (
         .clock  (clock),
         .comp   (comps[g]),
         .result (lanes[g])
      );
   end

   fvn_merge #(
      .COUNT_CAP (COUNT_CAP)
   ) u_merge (
      .clock (clock),
      .reset (reset),
      .valid (s1_valid_ff),
      .clear (merge_clear),
      .lanes (lanes),
      .acc   (acc)
   );

   fvn_root u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (acc.sum),
      .done     (root_done),
      .root     (root_value)
   );

   fvn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (root_value),
      .divisor  (acc.count),
      .done     (div_done),
      .quotient (div_value)
   );

   always_comb begin
      s1_valid_in = accept;
      s1_last_in  = req_last_atom;
      state_in    = state_ff;
      root_start  = 1'b0;
      div_start   = 1'b0;
      merge_clear = 1'b0;
      norm_in     = norm_ff;
      strobe_in   = 1'b0;
      max_in      = max_ff;
      rnorm_in    = rnorm_ff;
      ratio_in    = ratio_ff;
      count_in    = count_ff;
      sat_in      = sat_ff;
      unique case (state_ff)
         fvn_pkg::ST_ACCUM: begin
            // the merge takes the last item in this cycle
            if (s1_valid_ff && s1_last_ff) begin
               state_in = fvn_pkg::ST_START_ROOT;
            end
         end
         fvn_pkg::ST_START_ROOT: begin
            root_start = 1'b1;
            state_in   = fvn_pkg::ST_ROOT;
         end
         fvn_pkg::ST_ROOT: begin
            if (root_done) begin
               div_start = 1'b1;
               norm_in   = root_value;
               state_in  = fvn_pkg::ST_DIV;
            end
         end
         fvn_pkg::ST_DIV: begin
            if (div_done) begin
               strobe_in   = 1'b1;
               max_in      = acc.max_abs;
               rnorm_in    = norm_ff;
               ratio_in    = div_value;
               count_in    = acc.count;
               sat_in      = acc.sat;
               merge_clear = 1'b1;
               state_in    = fvn_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = fvn_pkg::ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= fvn_pkg::ST_ACCUM;
         s1_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
         strobe_ff   <= strobe_in;
      end
      s1_last_ff <= s1_last_in;
      norm_ff    <= norm_in;
      max_ff     <= max_in;
      rnorm_ff   <= rnorm_in;
      ratio_ff   <= ratio_in;
      count_ff   <= count_in;
      sat_ff     <= sat_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_max_abs_comp  = max_ff;
   assign rsp_norm_value    = rnorm_ff;
   assign rsp_norm_per_atom = ratio_ff;
   assign rsp_atoms_seen    = count_ff;
   assign rsp_sum_saturated = sat_ff;

`ifndef ASSERT_OFF
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_atom |=> busy)
      else $error("last item accepted but block not busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_atoms_seen != '0)
      else $error("result with zero atom count");

   a_ratio_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_norm_per_atom <= rsp_norm_value)
      else $error("per-atom norm exceeds norm");

   a_root_after_last: assert property (@(posedge clock) disable iff (reset)
      root_start |-> $past(s1_valid_ff && s1_last_ff))
      else $error("square root started without a last item");
`endif

endmodule

`default_nettype wire
